>>> rtl/qed_pkg.sv
// Shared types and constants for the quadrature encoder debounce unit.
package qed_pkg;

   typedef enum logic [1:0] {
      CMD_TICK          = 2'd0,
      CMD_READ_DELTA    = 2'd1,
      CMD_READ_PRESSES  = 2'd2,
      CMD_READ_RELEASES = 2'd3
   } qed_cmd_type;

   localparam logic [1:0] CsrReverse       = 2'd0;
   localparam logic [1:0] CsrAbStable      = 2'd1;
   localparam logic [1:0] CsrButtonStable  = 2'd2;

   localparam logic [1:0] LinesIdle = 2'b11;
   localparam logic signed [3:0] FullDetent = 4'sd4;

   localparam logic signed [31:0] DeltaMax = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] DeltaMin = 32'sh8000_0000;
   localparam logic [31:0]        CountMax = 32'hFFFF_FFFF;

   // Quarter-step weight, indexed by {previous lines, new lines}.
   localparam logic signed [3:0] QuarterTable [16] = '{
       4'sd0, -4'sd1,  4'sd1,  4'sd0,
       4'sd1,  4'sd0,  4'sd0, -4'sd1,
      -4'sd1,  4'sd0,  4'sd0,  4'sd1,
       4'sd0,  4'sd1, -4'sd1,  4'sd0
   };

   typedef struct packed {
      logic inc;
      logic dec;
   } qed_step_type;

endpackage

>>> rtl/quadrature_encoder_debounce_unit.sv
// Quadrature encoder decoder with line and button debounce.
//
// Each transaction on the req_ side is a sample tick or a read-and-clear
// command, and it yields exactly one transaction on the rsp_ side. One item
// is accepted per clock cycle while rsp_tready does not stall the result;
// its result passes the input register and then the result register. All
// state updates for an item lie between those registers, so the rate is
// set only by rsp_tready. Encoder lines must hold for ab_stable_ticks ticks
// before decoding, which starts once both lines read high; a full detent
// moves a saturating signed delta by one. The button is debounced on both
// edges and drives saturating press and release counters. On a tick the
// result shows state after the tick; on a read it shows values before the
// named counter is cleared. Configuration writes take effect at once and
// are meant to be made while the block is idle.
module quadrature_encoder_debounce_unit (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [1:0] lines_ab, [2] button_level
   input  logic [1:0]   req_tuser,   // [1:0] cmd
   // response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // [31:0] delta, [63:32] press_count,
                                     // [95:64] release_count, [96] button_down
   // configuration write port
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [7:0]   csr_wdata
);

   // configuration
   logic       reverse_ff;
   logic [7:0] ab_stable_ff;
   logic [7:0] btn_stable_ff;

   // input register
   logic                 s1_valid_ff;
   qed_pkg::qed_cmd_type s1_cmd_ff;
   logic [1:0]           s1_ab_ff;
   logic                 s1_level_ff;

   // block state
   logic signed [31:0] delta_ff, delta_in;
   logic [31:0]        press_ff, press_in;
   logic [31:0]        release_ff, release_in;
   logic               btn_ff, btn_in;
   logic [7:0]         btn_cnt_ff, btn_cnt_in;

   // result register
   logic               rsp_valid_ff;
   logic signed [31:0] out_delta_ff, out_delta_in;
   logic [31:0]        out_press_ff, out_press_in;
   logic [31:0]        out_release_ff, out_release_in;
   logic               out_btn_ff;

   logic                 advance;
   logic                 tick;
   qed_pkg::qed_step_type step;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign tick       = advance && (s1_cmd_ff == qed_pkg::CMD_TICK);

   qed_line_decoder u_line_decoder (
      .clock        (clock),
      .reset        (reset),
      .sample_en    (tick),
      .lines_ab     (s1_ab_ff),
      .stable_ticks (ab_stable_ff),
      .reverse      (reverse_ff),
      .step         (step)
   );

   always_comb begin
      delta_in       = delta_ff;
      press_in       = press_ff;
      release_in     = release_ff;
      btn_in         = btn_ff;
      btn_cnt_in     = btn_cnt_ff;
      out_delta_in   = delta_ff;
      out_press_in   = press_ff;
      out_release_in = release_ff;
      if (advance) begin
         unique case (s1_cmd_ff)
            qed_pkg::CMD_TICK: begin
               if (step.inc && (delta_ff != qed_pkg::DeltaMax)) begin
                  delta_in = delta_ff + 32'sd1;
               end else if (step.dec && (delta_ff != qed_pkg::DeltaMin)) begin
                  delta_in = delta_ff - 32'sd1;
               end
               if (s1_level_ff == btn_ff) begin
                  btn_cnt_in = '0;
               end else begin
                  btn_cnt_in = btn_cnt_ff + 8'd1;
                  if (btn_cnt_in >= btn_stable_ff) begin
                     btn_cnt_in = '0;
                     btn_in     = s1_level_ff;
                     if (s1_level_ff) begin
                        if (press_ff != qed_pkg::CountMax) press_in = press_ff + 32'd1;
                     end else begin
                        if (release_ff != qed_pkg::CountMax) begin
                           release_in = release_ff + 32'd1;
                        end
                     end
                  end
               end
               // show post-tick state
               out_delta_in   = delta_in;
               out_press_in   = press_in;
               out_release_in = release_in;
            end
            qed_pkg::CMD_READ_DELTA:    delta_in   = '0;
            qed_pkg::CMD_READ_PRESSES:  press_in   = '0;
            qed_pkg::CMD_READ_RELEASES: release_in = '0;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reverse_ff    <= 1'b0;
         ab_stable_ff  <= 8'd2;
         btn_stable_ff <= 8'd20;
      end else if (csr_we) begin
         unique case (csr_index)
            qed_pkg::CsrReverse:      reverse_ff    <= csr_wdata[0];
            qed_pkg::CsrAbStable:     ab_stable_ff  <= csr_wdata;
            qed_pkg::CsrButtonStable: btn_stable_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         delta_ff     <= '0;
         press_ff     <= '0;
         release_ff   <= '0;
         btn_ff       <= 1'b0;
         btn_cnt_ff   <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         delta_ff   <= delta_in;
         press_ff   <= press_in;
         release_ff <= release_in;
         btn_ff     <= btn_in;
         btn_cnt_ff <= btn_cnt_in;
      end
   end

   // payload registers: load on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_cmd_ff   <= qed_pkg::qed_cmd_type'(req_tuser[1:0]);
         s1_ab_ff    <= req_tdata[1:0];
         s1_level_ff <= req_tdata[2];
      end
      if (advance) begin
         out_delta_ff   <= out_delta_in;
         out_press_ff   <= out_press_in;
         out_release_ff <= out_release_in;
         out_btn_ff     <= btn_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, out_btn_ff, out_release_ff, out_press_ff, out_delta_ff};

`ifndef SYNTHESIS
   a_step_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(step.inc && step.dec))
      else $error("detent step both up and down");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff)
      else $error("input register dropped a stalled transaction");

   a_press_monotonic: assert property (@(posedge clock) disable iff (reset)
      !(advance && (s1_cmd_ff == qed_pkg::CMD_READ_PRESSES)) |=>
      press_ff >= $past(press_ff))
      else $error("press counter decreased without a clear");

   a_idle_state_frozen: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(delta_ff) && $stable(btn_ff))
      else $error("state moved without a transaction");
`endif

endmodule

>>> rtl/qed_line_decoder.sv
// Line debounce and four-phase detent decoder for the encoder lines.
module qed_line_decoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               sample_en,
   input  logic [1:0]         lines_ab,
   input  logic [7:0]         stable_ticks,
   input  logic               reverse,
   output qed_pkg::qed_step_type step
);

   logic [1:0]        cand_ff, cand_in;
   logic [7:0]        cnt_ff, cnt_in;
   logic [1:0]        prev_ff, prev_in;
   logic              sync_ff, sync_in;
   logic signed [3:0] phase_ff, phase_in;
   logic signed [3:0] phase_sum;

   assign phase_sum = phase_ff + qed_pkg::QuarterTable[{prev_ff, lines_ab}];

   always_comb begin
      cand_in  = cand_ff;
      cnt_in   = cnt_ff;
      prev_in  = prev_ff;
      sync_in  = sync_ff;
      phase_in = phase_ff;
      step     = '0;
      if (sample_en) begin
         if (lines_ab != cand_ff) begin
            cand_in = lines_ab;
            cnt_in  = 8'd1;
         end else if (cnt_ff < stable_ticks) begin
            cnt_in = cnt_ff + 8'd1;
         end
         if (cnt_in >= stable_ticks) begin
            priority if (!sync_ff) begin
               prev_in  = lines_ab;
               phase_in = '0;
               sync_in  = (lines_ab == qed_pkg::LinesIdle);
            end else if (lines_ab == prev_ff) begin
               prev_in = prev_ff;
            end else if ((lines_ab ^ prev_ff) == 2'b11) begin
               // both lines moved: drop the partial count and resync
               prev_in  = lines_ab;
               phase_in = '0;
               sync_in  = (lines_ab == qed_pkg::LinesIdle);
            end else begin
               prev_in = lines_ab;
               if (lines_ab == qed_pkg::LinesIdle) begin
                  phase_in = '0;
                  step.inc = reverse ? (phase_sum == -qed_pkg::FullDetent)
                                     : (phase_sum == qed_pkg::FullDetent);
                  step.dec = reverse ? (phase_sum == qed_pkg::FullDetent)
                                     : (phase_sum == -qed_pkg::FullDetent);
               end else begin
                  phase_in = phase_sum;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff  <= qed_pkg::LinesIdle;
         cnt_ff   <= '0;
         prev_ff  <= qed_pkg::LinesIdle;
         sync_ff  <= 1'b0;
         phase_ff <= '0;
      end else begin
         cand_ff  <= cand_in;
         cnt_ff   <= cnt_in;
         prev_ff  <= prev_in;
         sync_ff  <= sync_in;
         phase_ff <= phase_in;
      end
   end

endmodule
